// ===== design/tdfe_pkg.sv =====
// tdfe_pkg: types, constants and byte functions of the telemetry data frame encoder
// no dependencies; imported by every module of the block
package tdfe_pkg;

    localparam int PACKET_BYTES = 13;

    localparam logic [3:0] POS_SEP     = 4'd0;
    localparam logic [3:0] POS_PID     = 4'd1;
    localparam logic [3:0] POS_LEN     = 4'd2;
    localparam logic [3:0] POS_MAN_LO  = 4'd3;
    localparam logic [3:0] POS_MAN_HI  = 4'd4;
    localparam logic [3:0] POS_DEV_LO  = 4'd5;
    localparam logic [3:0] POS_DEV_HI  = 4'd6;
    localparam logic [3:0] POS_NULL    = 4'd7;
    localparam logic [3:0] POS_ENT_ONE = 4'd8;
    localparam logic [3:0] POS_VAL_ONE = 4'd9;
    localparam logic [3:0] POS_ENT_TWO = 4'd10;
    localparam logic [3:0] POS_VAL_TWO = 4'd11;
    localparam logic [3:0] POS_CRC     = 4'(PACKET_BYTES - 1);

    localparam logic [7:0] LEN_BYTE = 8'((PACKET_BYTES - 3) | 'h40);

    localparam logic [7:0] NO_NINTH_FF = 8'hFF;
    localparam logic [7:0] NO_NINTH_7E = 8'h7E;
    localparam logic [7:0] NO_NINTH_FE = 8'hFE;
    localparam logic [1:0] STOP_BITS   = 2'b11;

    localparam logic [7:0] RST_CRC_POLY  = 8'h07;
    localparam logic [7:0] RST_SEPARATOR = 8'h7E;
    localparam logic [7:0] RST_PACKET_ID = 8'h9F;
    localparam logic [7:0] RST_NULL      = 8'h00;
    localparam logic       RST_WORD_MODE = 1'b1;

    typedef enum logic [2:0] {
        CFG_CRC_POLY  = 3'd0,
        CFG_SEPARATOR = 3'd1,
        CFG_PACKET_ID = 3'd2,
        CFG_NULL      = 3'd3,
        CFG_WORD_MODE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] manufacturer_id;
        logic [15:0] device_id;
        logic [3:0]  ident_one;
        logic [3:0]  kind_one;
        logic [7:0]  value_one;
        logic [3:0]  ident_two;
        logic [3:0]  kind_two;
        logic [7:0]  value_two;
    } in_item_t;

    typedef struct packed {
        logic [12:0] code_word;
        logic [3:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef struct packed {
        logic [7:0] crc_poly;
        logic [7:0] separator_byte;
        logic [7:0] packet_id_byte;
        logic [7:0] null_byte;
        logic       word_mode;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [3:0] index;
        logic       last;
    } byte_req_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] reverse_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7 - k] = b[k];
        end
        return r;
    endfunction

    function automatic logic [12:0] encode_word(input logic [7:0] b, input logic mode);
        logic [7:0]  r;
        logic        ninth;
        logic [12:0] w;
        r     = reverse_byte(b);
        ninth = (b != NO_NINTH_FF) && (b != NO_NINTH_7E) && (b != NO_NINTH_FE);
        if (mode) begin
            w = {1'b0, r, ninth, 3'b000};
        end else begin
            w = {2'b00, r, 3'b000};
        end
        w[2]   = ~(^w[12:3]);
        w[1:0] = STOP_BITS;
        return w;
    endfunction

endpackage

// ===== design/tdfe_cfg_regs.sv =====
// tdfe_cfg_regs: configuration register file of the frame encoder
// depends on tdfe_pkg
module tdfe_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output tdfe_pkg::cfg_t cfg
);
    import tdfe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_CRC_POLY:  cfg_next.crc_poly       = cfg_data;
                CFG_SEPARATOR: cfg_next.separator_byte = cfg_data;
                CFG_PACKET_ID: cfg_next.packet_id_byte = cfg_data;
                CFG_NULL:      cfg_next.null_byte      = cfg_data;
                CFG_WORD_MODE: cfg_next.word_mode      = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_poly       <= RST_CRC_POLY;
            cfg_reg.separator_byte <= RST_SEPARATOR;
            cfg_reg.packet_id_byte <= RST_PACKET_ID;
            cfg_reg.null_byte      <= RST_NULL;
            cfg_reg.word_mode      <= RST_WORD_MODE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/tdfe_in_buf.sv =====
// tdfe_in_buf: one-entry input holding register for telemetry records
// depends on tdfe_pkg
module tdfe_in_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tdfe_pkg::in_item_t s_data,
    output logic               hold_valid,
    output tdfe_pkg::in_item_t hold_data,
    input  logic               pop
);
    import tdfe_pkg::*;

    logic     hold_valid_reg;
    logic     hold_valid_next;
    in_item_t hold_data_reg;

    assign s_ready    = !hold_valid_reg;
    assign hold_valid = hold_valid_reg;
    assign hold_data  = hold_data_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (pop) begin
            hold_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_data_reg <= s_data;
        end
    end

endmodule

// ===== design/tdfe_seq.sv =====
// tdfe_seq: packet sequencer, picks one packet byte per cycle while the word encoder is ready and runs the crc-8
// depends on tdfe_pkg
module tdfe_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  tdfe_pkg::cfg_t      cfg,
    input  logic                hold_valid,
    input  tdfe_pkg::in_item_t  hold_data,
    output logic                pop,
    input  logic                enc_ready,
    output tdfe_pkg::byte_req_t req
);
    import tdfe_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    in_item_t   rec_reg;
    logic [7:0] cur_byte;
    logic       emit;
    logic       done;

    always_comb begin
        case (idx_reg)
            POS_SEP:     cur_byte = cfg.separator_byte;
            POS_PID:     cur_byte = cfg.packet_id_byte;
            POS_LEN:     cur_byte = LEN_BYTE;
            POS_MAN_LO:  cur_byte = rec_reg.manufacturer_id[7:0];
            POS_MAN_HI:  cur_byte = rec_reg.manufacturer_id[15:8];
            POS_DEV_LO:  cur_byte = rec_reg.device_id[7:0];
            POS_DEV_HI:  cur_byte = rec_reg.device_id[15:8];
            POS_NULL:    cur_byte = cfg.null_byte;
            POS_ENT_ONE: cur_byte = {rec_reg.ident_one, rec_reg.kind_one};
            POS_VAL_ONE: cur_byte = rec_reg.value_one;
            POS_ENT_TWO: cur_byte = {rec_reg.ident_two, rec_reg.kind_two};
            POS_VAL_TWO: cur_byte = rec_reg.value_two;
            POS_CRC:     cur_byte = crc_reg;
            default:     cur_byte = 8'h00;
        endcase
    end

    assign emit = busy_reg && enc_ready;
    assign done = emit && (idx_reg == POS_CRC);
    assign pop  = hold_valid && (!busy_reg || done);

    assign req.valid = emit;
    assign req.data  = cur_byte;
    assign req.index = idx_reg;
    assign req.last  = (idx_reg == POS_CRC);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = POS_SEP;
            crc_next  = 8'h00;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 4'd1;
            if (idx_reg >= POS_LEN) begin
                crc_next = crc8_byte(crc_reg, cur_byte, cfg.crc_poly);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= POS_SEP;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (pop) begin
            rec_reg <= hold_data;
        end
    end

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= POS_CRC))
        else $error("sequencer index past crc position");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !hold_valid) |=> !busy_reg)
        else $error("sequencer still busy after last byte");

    a_pop_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (busy_reg && idx_reg == POS_SEP && crc_reg == 8'h00))
        else $error("new record did not restart at byte zero");

    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !done) |=> (idx_reg == $past(idx_reg) + 4'd1))
        else $error("sequencer skipped or repeated a byte");

endmodule

// ===== design/tdfe_word_enc.sv =====
// tdfe_word_enc: serial word encoder and output register of the frame encoder
// depends on tdfe_pkg
module tdfe_word_enc (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                word_mode,
    input  tdfe_pkg::byte_req_t req,
    output logic                enc_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tdfe_pkg::out_item_t m_data
);
    import tdfe_pkg::*;

    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_data_reg;
    out_item_t m_data_next;

    assign enc_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (enc_ready) begin
            m_valid_next = req.valid;
            if (req.valid) begin
                m_data_next.code_word  = encode_word(req.data, word_mode);
                m_data_next.word_index = req.index;
                m_data_next.last_word  = req.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_req_only_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid |-> enc_ready)
        else $error("byte offered while output register full");

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.last_word) |-> (m_data_reg.word_index == POS_CRC))
        else $error("last word flag away from crc position");

    a_stop_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.code_word[1:0] == STOP_BITS))
        else $error("stop bits missing");

endmodule

// ===== design/telemetry_data_frame_encoder.sv =====
// telemetry_data_frame_encoder: top level, record in, thirteen serial words out
// depends on tdfe_pkg, tdfe_cfg_regs, tdfe_in_buf, tdfe_seq, tdfe_word_enc
//
// s_* channel: one telemetry record per item (ids and two entries).
// m_* channel: thirteen items per record, one serial word each, with its byte
//   position and a flag on the closing crc word.
// cfg_* channel: register writes (crc polynomial, separator, packet id, null byte,
//   word mode), always ready, to be done while no packet is in flight.
// data path: input register, sequencer record register, output register.
// throughput: one word per cycle while the receiver takes words, set by the
//   packet sequencer that walks the thirteen byte positions in turn; a
//   second record is held in the input register while the current packet drains.
// receiver stall: the output register holds its word and the sequencer waits;
//   nothing is dropped, s_ready falls once the input register is also full.
// reset: synchronous, active low; clears all valid state and loads the register
//   defaults (poly 0x07, separator 0x7e, id 0x9f, null 0x00, word mode 1).
module telemetry_data_frame_encoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tdfe_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tdfe_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import tdfe_pkg::*;

    cfg_t      cfg;
    logic      hold_valid;
    in_item_t  hold_data;
    logic      pop;
    logic      enc_ready;
    byte_req_t req;

    tdfe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tdfe_in_buf u_in_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .hold_valid (hold_valid),
        .hold_data  (hold_data),
        .pop        (pop)
    );

    tdfe_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .hold_valid (hold_valid),
        .hold_data  (hold_data),
        .pop        (pop),
        .enc_ready  (enc_ready),
        .req        (req)
    );

    tdfe_word_enc u_word_enc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .word_mode (cfg.word_mode),
        .req       (req),
        .enc_ready (enc_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
